@@ hw/rtl/wheel_motor_drive_odometry_top_defines.svh @@
// Assertion macros for the wheel drive and odometry block.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef WHEEL_MOTOR_DRIVE_ODOMETRY_TOP_DEFINES_SVH
`define WHEEL_MOTOR_DRIVE_ODOMETRY_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WMDO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WMDO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define WMDO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WMDO_ASSERT(lbl, prop, msg)
`define WMDO_ASSERT_IMP(lbl, ante, cons, msg)
`define WMDO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/wmdo_pkg.sv @@
// Shared widths, codes and controller/datapath interface types for the wheel drive block.
// No dependencies.
package wmdo_pkg;

  localparam int TIME_W    = 32;
  localparam int RADIUS_W  = 10;
  localparam int TMO_W     = 16;
  localparam int SPEED_W   = 9;
  localparam int COUNT_W   = 32;
  localparam int RPM_W     = 16;
  localparam int VEL_W     = 23;
  localparam int DIST_W    = 45;
  localparam int DUTY_W    = 8;
  localparam int FRAC_BITS = 11;

  // Opcodes of an input request.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_PULSE   = 2'd1;
  localparam logic [1:0] OP_SPEED   = 2'd2;
  localparam logic [1:0] OP_REFRESH = 2'd3;

  // Divider for 1000 / interval.
  localparam int DIV_W       = 10;
  localparam int DIV_STEPS   = DIV_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam logic [DIV_W-1:0] DIVIDEND    = DIV_W'(1000);
  localparam logic [DIV_W-1:0] DIVISOR_BIG = DIV_W'(1001);
  localparam int MS_PER_S    = 1000;

  // Fixed-point scale factors.
  localparam int VEL_MUL_W  = 8;
  localparam int DIST_MUL_W = 14;
  localparam logic [VEL_MUL_W-1:0]  VEL_MUL  = VEL_MUL_W'(213);
  localparam logic [DIST_MUL_W-1:0] DIST_MUL = DIST_MUL_W'(12868);
  localparam int KV_W    = RADIUS_W + VEL_MUL_W;
  localparam int KD_W    = RADIUS_W + DIST_MUL_W;
  localparam int VPROD_W = KV_W + RPM_W;
  localparam int DPROD_W = COUNT_W + KD_W;

  // Configuration port.
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_LSB = 2;
  localparam int REG_IDX_W   = PADDR_W - REG_IDX_LSB;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INVERSE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 2'd2;
  localparam logic [RADIUS_W-1:0]  RADIUS_RST  = RADIUS_W'(50);
  localparam logic [TMO_W-1:0]     TIMEOUT_RST = TMO_W'(250);

  typedef struct packed {
    logic accept;
    logic div_step;
    logic mul1;
    logic mul2;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

@@ hw/rtl/wmdo_ctrl.sv @@
// Sequencing controller for the wheel drive block: handshakes and datapath commands.
// Depends on wmdo_pkg and the assertion macro header.
`include "wheel_motor_drive_odometry_top_defines.svh"

module wmdo_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  output logic               out_valid,
  input  logic               out_stall,
  output wmdo_pkg::dp_cmd_t  cmd,
  input  wmdo_pkg::dp_sts_t  sts
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL1 = 5'b00100,
    S_MUL2 = 5'b01000,
    S_LOAD = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.div_step = (state_r == S_DIV);
    cmd.mul1     = (state_r == S_MUL1);
    cmd.mul2     = (state_r == S_MUL2);
    // The result register may be refilled once the previous request has been taken.
    cmd.load     = (state_r == S_LOAD) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_opcode == wmdo_pkg::OP_PULSE) ? S_DIV : S_LOAD;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_LOAD;
      S_LOAD: begin
        if (cmd.load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `WMDO_ASSERT_NEXT(a_pulse_enters_div, accept && (in_opcode == wmdo_pkg::OP_PULSE), state_r == S_DIV, "pulse request did not start the divider")
  `WMDO_ASSERT_NEXT(a_short_op_to_load, accept && (in_opcode != wmdo_pkg::OP_PULSE), state_r == S_LOAD, "single-cycle request did not go to result load")
  `WMDO_ASSERT_NEXT(a_div_end_to_mul, (state_r == S_DIV) && sts.div_done, state_r == S_MUL1, "divider end not followed by multiply")
  `WMDO_ASSERT_NEXT(a_load_shows_result, cmd.load, out_valid_r && (state_r == S_IDLE), "loaded result not presented")

endmodule

@@ hw/rtl/wmdo_dp.sv @@
// Datapath of the wheel drive block: time base, pulse counter, divider, fixed-point
// multipliers, drive outputs and the result register. Depends on wmdo_pkg.
module wmdo_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wmdo_pkg::dp_cmd_t                     cmd,
  output wmdo_pkg::dp_sts_t                     sts,
  input  logic [1:0]                            in_opcode,
  input  logic signed [wmdo_pkg::SPEED_W-1:0]   in_speed_command,
  input  logic [wmdo_pkg::RADIUS_W-1:0]         radius,
  input  logic                                  inverse,
  input  logic [wmdo_pkg::TMO_W-1:0]            timeout,
  output logic signed [wmdo_pkg::COUNT_W-1:0]   out_pulse_count,
  output logic [wmdo_pkg::RPM_W-1:0]            out_wheel_rpm,
  output logic [wmdo_pkg::VEL_W-1:0]            out_velocity_mm_s,
  output logic signed [wmdo_pkg::DIST_W-1:0]    out_distance_mm,
  output logic                                  out_drive_direction,
  output logic [wmdo_pkg::DUTY_W-1:0]           out_pwm_duty,
  output logic                                  out_brake_on,
  output logic                                  out_timed_out
);

  // Architectural state.
  logic [wmdo_pkg::TIME_W-1:0]  now_r, now_nxt;
  logic [wmdo_pkg::TIME_W-1:0]  last_r, last_nxt;
  logic [wmdo_pkg::TIME_W-1:0]  refresh_r, refresh_nxt;
  logic [wmdo_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [wmdo_pkg::RPM_W-1:0]   rpm_r, rpm_nxt;
  logic [wmdo_pkg::VEL_W-1:0]   vel_r, vel_nxt;
  logic [wmdo_pkg::DIST_W-1:0]  dist_r, dist_nxt;
  logic                         dir_r, dir_nxt;
  logic [wmdo_pkg::DUTY_W-1:0]  duty_r, duty_nxt;
  logic                         brake_r, brake_nxt;
  logic                         fired_r, fired_nxt;

  // Divider and multiplier working registers.
  logic [wmdo_pkg::DIV_W-1:0]     dsr_r, dsr_nxt;
  logic [wmdo_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [wmdo_pkg::DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [wmdo_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [wmdo_pkg::DIV_CNT_W-1:0] step_r, step_nxt;
  logic [wmdo_pkg::KV_W-1:0]      kv_r, kv_nxt;
  logic [wmdo_pkg::KD_W-1:0]      kd_r, kd_nxt;

  logic [wmdo_pkg::TIME_W-1:0]  tick_now;
  logic [wmdo_pkg::TIME_W-1:0]  since_refresh;
  logic [wmdo_pkg::TIME_W-1:0]  interval;
  logic [wmdo_pkg::DIV_W:0]     trial;
  logic                         trial_ge;
  logic [wmdo_pkg::RPM_W-1:0]   rpm_calc;
  logic [wmdo_pkg::VPROD_W-1:0] vel_prod;
  logic signed [wmdo_pkg::COUNT_W-1:0] cnt_s;
  logic signed [wmdo_pkg::KD_W:0]      kd_s;
  logic signed [wmdo_pkg::DPROD_W-1:0] dist_prod;
  logic                         speed_neg;
  logic [wmdo_pkg::SPEED_W-1:0] speed_u;
  logic [wmdo_pkg::SPEED_W-1:0] speed_mag;

  assign tick_now      = now_r + wmdo_pkg::TIME_W'(1);
  assign since_refresh = tick_now - refresh_r;
  assign interval      = now_r - last_r;

  assign trial    = {rem_r, dvd_r[wmdo_pkg::DIV_W-1]};
  assign trial_ge = trial >= {1'b0, dsr_r};
  assign sts.div_done = (step_r == wmdo_pkg::DIV_CNT_W'(wmdo_pkg::DIV_STEPS - 1));

  // rpm = quotient * 60, as two shifts and a subtract.
  assign rpm_calc = (wmdo_pkg::RPM_W'(quo_r) << 6) - (wmdo_pkg::RPM_W'(quo_r) << 2);

  assign vel_prod  = wmdo_pkg::VPROD_W'(kv_r) * wmdo_pkg::VPROD_W'(rpm_r);
  assign cnt_s     = $signed(count_r);
  assign kd_s      = $signed({1'b0, kd_r});
  assign dist_prod = wmdo_pkg::DPROD_W'(cnt_s) * wmdo_pkg::DPROD_W'(kd_s);

  assign speed_u   = $unsigned(in_speed_command);
  assign speed_neg = speed_u[wmdo_pkg::SPEED_W-1];
  assign speed_mag = speed_neg ? (wmdo_pkg::SPEED_W'(0) - speed_u) : speed_u;

  always_comb begin
    now_nxt     = now_r;
    last_nxt    = last_r;
    refresh_nxt = refresh_r;
    count_nxt   = count_r;
    rpm_nxt     = rpm_r;
    vel_nxt     = vel_r;
    dist_nxt    = dist_r;
    dir_nxt     = dir_r;
    duty_nxt    = duty_r;
    brake_nxt   = brake_r;
    fired_nxt   = fired_r;
    dsr_nxt     = dsr_r;
    rem_nxt     = rem_r;
    dvd_nxt     = dvd_r;
    quo_nxt     = quo_r;
    step_nxt    = step_r;
    kv_nxt      = kv_r;
    kd_nxt      = kd_r;

    if (cmd.accept) begin
      fired_nxt = 1'b0;
      case (in_opcode)
        wmdo_pkg::OP_TICK: begin
          now_nxt = tick_now;
          if (since_refresh > wmdo_pkg::TIME_W'(timeout)) begin
            rpm_nxt   = '0;
            vel_nxt   = '0;
            fired_nxt = 1'b1;
          end
        end
        wmdo_pkg::OP_PULSE: begin
          count_nxt = dir_r ? count_r + wmdo_pkg::COUNT_W'(1)
                            : count_r - wmdo_pkg::COUNT_W'(1);
          last_nxt  = now_r;
          // A same-millisecond pulse divides by one; past one second the quotient is zero.
          if (interval == '0) begin
            dsr_nxt = wmdo_pkg::DIV_W'(1);
          end else if (interval > wmdo_pkg::TIME_W'(wmdo_pkg::MS_PER_S)) begin
            dsr_nxt = wmdo_pkg::DIVISOR_BIG;
          end else begin
            dsr_nxt = interval[wmdo_pkg::DIV_W-1:0];
          end
          rem_nxt  = '0;
          dvd_nxt  = wmdo_pkg::DIVIDEND;
          quo_nxt  = '0;
          step_nxt = '0;
        end
        wmdo_pkg::OP_SPEED: begin
          if (speed_u == '0) begin
            brake_nxt = 1'b1;
            dir_nxt   = 1'b0;
            duty_nxt  = '0;
          end else begin
            dir_nxt   = speed_neg ? inverse : !inverse;
            duty_nxt  = speed_mag[wmdo_pkg::DUTY_W-1:0];
            brake_nxt = 1'b0;
          end
        end
        wmdo_pkg::OP_REFRESH: begin
          refresh_nxt = now_r;
        end
        default: begin
          refresh_nxt = refresh_r;
        end
      endcase
    end

    if (cmd.div_step) begin
      rem_nxt  = trial_ge ? (trial[wmdo_pkg::DIV_W-1:0] - dsr_r) : trial[wmdo_pkg::DIV_W-1:0];
      quo_nxt  = {quo_r[wmdo_pkg::DIV_W-2:0], trial_ge};
      dvd_nxt  = dvd_r << 1;
      step_nxt = step_r + wmdo_pkg::DIV_CNT_W'(1);
    end

    if (cmd.mul1) begin
      rpm_nxt = rpm_calc;
      kv_nxt  = wmdo_pkg::KV_W'(radius) * wmdo_pkg::KV_W'(wmdo_pkg::VEL_MUL);
      kd_nxt  = wmdo_pkg::KD_W'(radius) * wmdo_pkg::KD_W'(wmdo_pkg::DIST_MUL);
    end

    if (cmd.mul2) begin
      vel_nxt  = vel_prod[wmdo_pkg::FRAC_BITS +: wmdo_pkg::VEL_W];
      // Bit selection of the signed product is the floor of the arithmetic shift.
      dist_nxt = dist_prod[wmdo_pkg::FRAC_BITS +: wmdo_pkg::DIST_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r     <= '0;
      last_r    <= '0;
      refresh_r <= '0;
      count_r   <= '0;
      rpm_r     <= '0;
      vel_r     <= '0;
      dist_r    <= '0;
      dir_r     <= 1'b0;
      duty_r    <= '0;
      brake_r   <= 1'b1;
      fired_r   <= 1'b0;
    end else begin
      now_r     <= now_nxt;
      last_r    <= last_nxt;
      refresh_r <= refresh_nxt;
      count_r   <= count_nxt;
      rpm_r     <= rpm_nxt;
      vel_r     <= vel_nxt;
      dist_r    <= dist_nxt;
      dir_r     <= dir_nxt;
      duty_r    <= duty_nxt;
      brake_r   <= brake_nxt;
      fired_r   <= fired_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dsr_r  <= dsr_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    kv_r   <= kv_nxt;
    kd_r   <= kd_nxt;
    if (cmd.load) begin
      out_pulse_count     <= $signed(count_r);
      out_wheel_rpm       <= rpm_r;
      out_velocity_mm_s   <= vel_r;
      out_distance_mm     <= $signed(dist_r);
      out_drive_direction <= dir_r;
      out_pwm_duty        <= duty_r;
      out_brake_on        <= brake_r;
      out_timed_out       <= fired_r;
    end
  end

endmodule

@@ hw/rtl/wheel_motor_drive_odometry_top.sv @@
// Top level of the wheel drive and odometry block: configuration registers and the
// controller/datapath pair. Depends on wmdo_pkg, wmdo_ctrl and wmdo_dp.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  in_opcode, in_speed_command
//   out      out_valid/out_stall  pulse count, rpm, velocity, distance, drive, timed_out
//   config   psel/penable/pready  paddr, pwdata, prdata (32-bit registers at 4*index)
//
// A tick, speed or refresh request goes straight from acceptance to the result load.
// A pulse request first runs the restoring divider for 1000/interval, one quotient bit
// per cycle, then two multiply stages and the result load.
// Reset is synchronous and clears all but the working and output registers; no requests
// are taken during it. A stalled result holds in the output register; the block
// finishes the next request but does not load it until the pending result has been taken.
module wheel_motor_drive_odometry_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_opcode,
  input  logic signed [wmdo_pkg::SPEED_W-1:0]   in_speed_command,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [wmdo_pkg::COUNT_W-1:0]   out_pulse_count,
  output logic [wmdo_pkg::RPM_W-1:0]            out_wheel_rpm,
  output logic [wmdo_pkg::VEL_W-1:0]            out_velocity_mm_s,
  output logic signed [wmdo_pkg::DIST_W-1:0]    out_distance_mm,
  output logic                                  out_drive_direction,
  output logic [wmdo_pkg::DUTY_W-1:0]           out_pwm_duty,
  output logic                                  out_brake_on,
  output logic                                  out_timed_out,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [wmdo_pkg::PADDR_W-1:0]          paddr,
  input  logic [wmdo_pkg::PDATA_W-1:0]          pwdata,
  output logic [wmdo_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready
);

  logic [wmdo_pkg::RADIUS_W-1:0]  radius_r, radius_nxt;
  logic                           inverse_r, inverse_nxt;
  logic [wmdo_pkg::TMO_W-1:0]     timeout_r, timeout_nxt;
  logic                           cfg_wr;
  logic [wmdo_pkg::REG_IDX_W-1:0] cfg_idx;

  wmdo_pkg::dp_cmd_t cmd;
  wmdo_pkg::dp_sts_t sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[wmdo_pkg::PADDR_W-1:wmdo_pkg::REG_IDX_LSB];

  always_comb begin
    radius_nxt  = radius_r;
    inverse_nxt = inverse_r;
    timeout_nxt = timeout_r;
    if (cfg_wr) begin
      case (cfg_idx)
        wmdo_pkg::REG_RADIUS:  radius_nxt  = pwdata[wmdo_pkg::RADIUS_W-1:0];
        wmdo_pkg::REG_INVERSE: inverse_nxt = pwdata[0];
        wmdo_pkg::REG_TIMEOUT: timeout_nxt = pwdata[wmdo_pkg::TMO_W-1:0];
        default:               radius_nxt  = radius_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      wmdo_pkg::REG_RADIUS:  prdata = wmdo_pkg::PDATA_W'(radius_r);
      wmdo_pkg::REG_INVERSE: prdata = wmdo_pkg::PDATA_W'(inverse_r);
      wmdo_pkg::REG_TIMEOUT: prdata = wmdo_pkg::PDATA_W'(timeout_r);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= wmdo_pkg::RADIUS_RST;
      inverse_r <= 1'b0;
      timeout_r <= wmdo_pkg::TIMEOUT_RST;
    end else begin
      radius_r  <= radius_nxt;
      inverse_r <= inverse_nxt;
      timeout_r <= timeout_nxt;
    end
  end

  wmdo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  wmdo_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_opcode           (in_opcode),
    .in_speed_command    (in_speed_command),
    .radius              (radius_r),
    .inverse             (inverse_r),
    .timeout             (timeout_r),
    .out_pulse_count     (out_pulse_count),
    .out_wheel_rpm       (out_wheel_rpm),
    .out_velocity_mm_s   (out_velocity_mm_s),
    .out_distance_mm     (out_distance_mm),
    .out_drive_direction (out_drive_direction),
    .out_pwm_duty        (out_pwm_duty),
    .out_brake_on        (out_brake_on),
    .out_timed_out       (out_timed_out)
  );

endmodule
